/* rtl/krts_pkg.sv */
// Package: shared types, constants and codes for the keyed roster table.
`timescale 1ns / 1ps
package krts_pkg;

  localparam int MaxEntriesDefault = 16;
  localparam int KeyW   = 8;
  localparam int PosW   = 16;
  localparam int SmW    = 24;
  localparam int ColW   = 24;
  localparam int GainW  = 16;
  localparam int CountW = 5;

  localparam logic signed [PosW-1:0] JoinPos = 16'sd80;
  // Snap threshold 6400 pixels squared in Q.16.
  localparam logic [47:0] SnapDist2 = 48'd6400 << 16;

  typedef enum logic [1:0] {
    OP_LEAVE = 2'd0,
    OP_JOIN  = 2'd1,
    OP_STATE = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [KeyW-1:0]        player_id;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [ColW-1:0]        color;
    logic [GainW-1:0]       gain;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [KeyW-1:0]        entry_key;
    logic signed [PosW-1:0] shown_x;
    logic signed [PosW-1:0] shown_y;
    logic [ColW-1:0]        shown_color;
    logic [CountW-1:0]      live_count;
    logic                   was_found;
    logic                   dropped;
    logic                   last;
  } out_item_t;

  // Truncate a Q.8 value toward zero to whole pixels.
  function automatic logic [PosW-1:0] pix(input logic signed [SmW-1:0] q);
    logic signed [SmW-1:0] a;
    logic signed [SmW-1:0] t;
    begin
      a = q[SmW-1] ? -q : q;
      t = a >>> 8;
      if (q[SmW-1]) t = -t;
      pix = t[PosW-1:0];
    end
  endfunction

endpackage

/* rtl/krts_if.sv */
// Interfaces: valid/ready channels for input and result transactions.
`timescale 1ns / 1ps
interface krts_in_if import krts_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface krts_out_if import krts_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/krts_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module krts_mul import krts_pkg::*; (
  input  logic                clk,
  input  logic signed [24:0]  a,
  input  logic signed [24:0]  b,
  output logic signed [49:0]  p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

/* rtl/keyed_roster_table_with_smoothing_core.sv */
// Top level: keyed roster table with iterative search, edit and smoothing.
`timescale 1ns / 1ps
// The block holds up to MAX_ENTRIES entries in register arrays and handles one
// transaction at a time. A leave, join or state message scans the keys one
// entry a cycle to find the first match, then edits the table and builds the
// acknowledgement in S_EDIT, loads it into the result register in S_ACK once
// that register is free, and yields one acknowledgement.
// A tick walks the entries in order; for each it uses the single shared
// multiplier four times (dx squared, dy squared, dx times gain, dy times gain)
// with a register after every product, so an entry passes through S_MDX,
// S_MDY, S_MGX, S_MGY, S_MWT and S_EMIT, waiting in S_EMIT until its report
// can be taken; a tick on an empty table yields one empty result. The input
// is ready only when the sequencer is idle and the result register is empty
// or being emptied. The colour register is written whenever cfg_we is high
// and is sampled by state messages that create new entries.
module keyed_roster_table_with_smoothing_core import krts_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  krts_in_if.sink           in_ch,
  krts_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [ColW-1:0]   cfg_wdata
);
  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FIND  = 10'b0000000010,
    S_EDIT  = 10'b0000000100,
    S_ACK   = 10'b0000001000,
    S_MDX   = 10'b0000010000,
    S_MDY   = 10'b0000100000,
    S_MGX   = 10'b0001000000,
    S_MGY   = 10'b0010000000,
    S_MWT   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ColW-1:0] peer_r;
  logic [CntW-1:0] count_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] scan_r;
  logic            found_r;
  in_item_t        item_r;

  logic [KeyW-1:0]        key_m [MAX_ENTRIES];
  logic signed [PosW-1:0] tx_m  [MAX_ENTRIES];
  logic signed [PosW-1:0] ty_m  [MAX_ENTRIES];
  logic signed [SmW-1:0]  sx_m  [MAX_ENTRIES];
  logic signed [SmW-1:0]  sy_m  [MAX_ENTRIES];
  logic [ColW-1:0]        col_m [MAX_ENTRIES];

  logic signed [24:0] dx_r, dy_r;
  logic [47:0]        d2_r;
  logic               snap_r;
  logic signed [SmW-1:0] gx_r;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_r;

  logic      ovalid_r;
  out_item_t odata_r;

  krts_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  wire out_free = !ovalid_r || out_ch.ready;
  wire out_load = ((state_r == S_ACK) || (state_r == S_EMIT)) && out_free;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  wire in_acc   = in_ch.valid && in_ch.ready;
  wire [IdxW-1:0] scan_ix = scan_r[IdxW-1:0];
  wire [IdxW-1:0] last_ix = IdxW'(count_r - CntW'(1));
  wire full = (count_r == CntW'(MAX_ENTRIES));

  // Multiplier operand selection by step; dy times gain is held through the
  // report so that the product stays put while the result waits.
  always_comb begin
    mul_a = dx_r;
    mul_b = dx_r;
    unique case (state_r)
      S_MDY:   begin mul_a = dx_r; mul_b = dx_r; end
      S_MGX:   begin mul_a = dy_r; mul_b = dy_r; end
      S_MGY:   begin mul_a = dx_r; mul_b = 25'(signed'({1'b0, item_r.gain})); end
      S_MWT,
      S_EMIT:  begin mul_a = dy_r; mul_b = 25'(signed'({1'b0, item_r.gain})); end
      default: begin mul_a = dx_r; mul_b = dx_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_ch.data.op == OP_TICK) state_nxt = (count_r == '0) ? S_ACK : S_MDX;
        else state_nxt = S_FIND;
      end
      S_FIND: if (found_r || scan_r == count_r) state_nxt = S_EDIT;
      S_EDIT: state_nxt = S_ACK;
      S_ACK:  if (out_free) state_nxt = S_IDLE;
      S_MDX:  state_nxt = S_MDY;
      S_MDY:  state_nxt = S_MGX;
      S_MGX:  state_nxt = S_MGY;
      S_MGY:  state_nxt = S_MWT;
      S_MWT:  state_nxt = S_EMIT;
      S_EMIT: if (out_free)
        state_nxt = (scan_r + CntW'(1) == count_r) ? S_IDLE : S_MDX;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      peer_r   <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      scan_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) peer_r <= cfg_wdata;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          item_r  <= in_ch.data;
          scan_r  <= '0;
          found_r <= 1'b0;
        end
        S_FIND: if (!found_r && scan_r != count_r) begin
          if (key_m[scan_ix] == item_r.player_id) begin
            found_r <= 1'b1;
            idx_r   <= scan_ix;
          end else begin
            scan_r <= scan_r + CntW'(1);
          end
        end
        S_EDIT: begin
          out_item_t ack;
          logic [IdxW-1:0] w;
          logic signed [PosW-1:0] nx, ny;
          ack = '0;
          ack.kind      = KIND_ACK;
          ack.entry_key = item_r.player_id;
          ack.was_found = found_r;
          ack.last      = 1'b1;
          w  = found_r ? idx_r : count_r[IdxW-1:0];
          nx = (item_r.op == OP_JOIN) ? JoinPos : item_r.pos_x;
          ny = (item_r.op == OP_JOIN) ? JoinPos : item_r.pos_y;
          unique case (item_r.op)
            OP_LEAVE: if (found_r) begin
              key_m[idx_r] <= key_m[last_ix];
              tx_m[idx_r]  <= tx_m[last_ix];
              ty_m[idx_r]  <= ty_m[last_ix];
              sx_m[idx_r]  <= sx_m[last_ix];
              sy_m[idx_r]  <= sy_m[last_ix];
              col_m[idx_r] <= col_m[last_ix];
              count_r <= count_r - CntW'(1);
            end
            OP_JOIN, OP_STATE: begin
              if (found_r && item_r.op == OP_STATE) begin
                tx_m[idx_r] <= item_r.pos_x;
                ty_m[idx_r] <= item_r.pos_y;
              end else if (found_r || !full) begin
                key_m[w] <= item_r.player_id;
                tx_m[w]  <= nx;
                ty_m[w]  <= ny;
                sx_m[w]  <= {nx, 8'h00};
                sy_m[w]  <= {ny, 8'h00};
                col_m[w] <= (item_r.op == OP_JOIN) ? item_r.color : peer_r;
                if (!found_r) count_r <= count_r + CntW'(1);
              end else begin
                ack.dropped = 1'b1;
              end
            end
            default: ;
          endcase
          odata_r <= ack;
        end
        S_ACK: if (out_free) begin
          if (item_r.op == OP_TICK) begin
            odata_r <= '{kind: KIND_EMPTY, last: 1'b1, default: '0};
          end else begin
            odata_r.live_count <= CountW'(count_r);
          end
        end
        S_MDX: begin
          dx_r <= 25'(signed'({tx_m[scan_ix], 8'h00})) - 25'(sx_m[scan_ix]);
          dy_r <= 25'(signed'({ty_m[scan_ix], 8'h00})) - 25'(sy_m[scan_ix]);
        end
        S_MDY: ;
        S_MGX: d2_r <= prod_r[47:0];
        S_MGY: snap_r <= ({1'b0, d2_r} + {1'b0, prod_r[47:0]}) > {1'b0, SnapDist2};
        S_MWT: gx_r <= SmW'(prod_r >>> 16);
        S_EMIT: if (out_free) begin
          logic signed [SmW-1:0] nsx, nsy;
          // prod_r holds dy*gain; dx*gain was captured in gx_r.
          nsx = snap_r ? SmW'({tx_m[scan_ix], 8'h00})
                       : sx_m[scan_ix] + gx_r;
          nsy = snap_r ? SmW'({ty_m[scan_ix], 8'h00})
                       : sy_m[scan_ix] + SmW'(prod_r >>> 16);
          sx_m[scan_ix] <= nsx;
          sy_m[scan_ix] <= nsy;
          odata_r.kind        <= KIND_REPORT;
          odata_r.entry_key   <= key_m[scan_ix];
          odata_r.shown_x     <= pix(nsx);
          odata_r.shown_y     <= pix(nsy);
          odata_r.shown_color <= col_m[scan_ix];
          odata_r.live_count  <= CountW'(count_r);
          odata_r.was_found   <= 1'b0;
          odata_r.dropped     <= 1'b0;
          odata_r.last        <= (scan_r + CntW'(1) == count_r);
          scan_r <= scan_r + CntW'(1);
        end
        default: ;
      endcase
    end
  end

  // The table never holds more than its capacity.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CntW'(MAX_ENTRIES))
    else $error("entry count above capacity");
  // Input is only taken while the sequencer is idle.
  assert property (@(posedge clk) disable iff (!rst_n) in_ch.ready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  // A leave never grows the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT && item_r.op == OP_LEAVE) |=> count_r <= $past(count_r))
    else $error("leave grew the table");
endmodule

/* tb/sv/tb_top.sv */
// Testbench for the keyed roster table: directed and random message/tick traffic with checking.
`timescale 1ns / 1ps
module tb_top;
  import krts_pkg::*;

  localparam int NumEntries = 16;
  localparam int IdleLimit  = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ColW-1:0] cfg_wdata = '0;

  krts_in_if  in_ch ();
  krts_out_if out_ch ();

  keyed_roster_table_with_smoothing_core #(.MAX_ENTRIES(NumEntries)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the roster, kept in step with every accepted transaction.
  logic [23:0]        shade_colour;
  int                 roster_len;
  logic [KeyW-1:0]    roster_key [NumEntries];
  int                 roster_tx  [NumEntries];
  int                 roster_ty  [NumEntries];
  longint             roster_sx  [NumEntries];
  longint             roster_sy  [NumEntries];
  logic [ColW-1:0]    roster_col [NumEntries];

  out_item_t pending_reports [$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        long_hold = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  function automatic logic [PosW-1:0] whole_pixels(longint q);
    longint v;
    v = (q >= 0) ? q / 256 : -((-q) / 256);
    return v[PosW-1:0];
  endfunction

  function automatic longint floor_q16(longint p);
    return (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
  endfunction

  function automatic out_item_t make_report(kind_t k, logic [7:0] key, logic [15:0] sx,
                                            logic [15:0] sy, logic [23:0] col,
                                            bit fnd, bit drp, bit lst);
    out_item_t r;
    r.kind = k; r.entry_key = key; r.shown_x = sx; r.shown_y = sy;
    r.shown_color = col; r.live_count = roster_len[4:0];
    r.was_found = fnd; r.dropped = drp; r.last = lst;
    return r;
  endfunction

  task automatic place_entry(int i, logic [7:0] key, int x, int y, logic [23:0] col);
    roster_key[i] = key; roster_tx[i] = x; roster_ty[i] = y;
    roster_sx[i] = x * 256; roster_sy[i] = y * 256; roster_col[i] = col;
  endtask

  // Works out the results of one accepted transaction and updates the shadow roster.
  task automatic predict_roster(in_item_t it);
    int  idx;
    bit  drp;
    longint dx, dy;
    idx = -1;
    drp = 1'b0;
    if (op_t'(it.op) == OP_TICK) begin
      if (roster_len == 0) begin
        pending_reports.push_back(make_report(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1));
        return;
      end
      for (int i = 0; i < roster_len; i++) begin
        dx = longint'(roster_tx[i]) * 256 - roster_sx[i];
        dy = longint'(roster_ty[i]) * 256 - roster_sy[i];
        if (dx * dx + dy * dy > 64'd6400 * 65536) begin
          roster_sx[i] = roster_tx[i] * 256;
          roster_sy[i] = roster_ty[i] * 256;
        end else begin
          roster_sx[i] += floor_q16(dx * it.gain);
          roster_sy[i] += floor_q16(dy * it.gain);
        end
        pending_reports.push_back(make_report(KIND_REPORT, roster_key[i],
          whole_pixels(roster_sx[i]), whole_pixels(roster_sy[i]), roster_col[i],
          0, 0, i == roster_len - 1));
      end
      return;
    end
    for (int i = roster_len - 1; i >= 0; i--)
      if (roster_key[i] == it.player_id) idx = i;
    case (op_t'(it.op))
      OP_LEAVE: begin
        if (idx >= 0) begin
          roster_key[idx] = roster_key[roster_len-1];
          roster_tx[idx] = roster_tx[roster_len-1];
          roster_ty[idx] = roster_ty[roster_len-1];
          roster_sx[idx] = roster_sx[roster_len-1];
          roster_sy[idx] = roster_sy[roster_len-1];
          roster_col[idx] = roster_col[roster_len-1];
          roster_len--;
        end
      end
      OP_JOIN: begin
        if (idx >= 0) place_entry(idx, it.player_id, 80, 80, it.color);
        else if (roster_len < NumEntries) begin
          place_entry(roster_len, it.player_id, 80, 80, it.color);
          roster_len++;
        end else drp = 1'b1;
      end
      default: begin
        if (idx >= 0) begin
          roster_tx[idx] = it.pos_x;
          roster_ty[idx] = it.pos_y;
        end else if (roster_len < NumEntries) begin
          place_entry(roster_len, it.player_id, it.pos_x, it.pos_y, shade_colour);
          roster_len++;
        end else drp = 1'b1;
      end
    endcase
    pending_reports.push_back(make_report(KIND_ACK, it.player_id, 0, 0, 0,
                                          idx >= 0, drp, 1));
  endtask

  // Sends one transaction, honouring the burst and gap pattern of the sender.
  // Valid stays high after an accept so that the next transaction of a burst
  // can follow at once; gaps and draining lower it.
  task automatic send_item(op_t op, logic [7:0] id, logic [15:0] x, logic [15:0] y,
                           logic [23:0] col, logic [15:0] g);
    in_item_t it;
    it.op = op; it.player_id = id; it.pos_x = x; it.pos_y = y; it.color = col; it.gain = g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_left != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_roster(it);
  endtask

  // Waits until every expected result has been taken and the block has settled.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_shade(logic [23:0] v);
    drain_block();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shade_colour = v;
  endtask

  function automatic logic [7:0] pick_key();
    // Favour keys already in the table so that most messages hit.
    if (roster_len > 0 && $urandom_range(0, 3) != 0)
      return roster_key[$urandom_range(0, roster_len - 1)];
    return $urandom_range(0, 23) == 0 ? 8'($urandom) : 8'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic test_directed_edges();
    send_item(OP_TICK, 8'h00, 0, 0, 0, 16'hffff);
    send_item(OP_LEAVE, 8'h05, 0, 0, 0, 0);
    send_item(OP_JOIN, 8'h00, 0, 0, 24'hff0000, 0);
    send_item(OP_JOIN, 8'hff, 0, 0, 24'hffffff, 0);
    send_item(OP_STATE, 8'h00, 16'h7fff, 16'h8000, 0, 0);
    send_item(OP_STATE, 8'h33, 16'h8000, 16'h7fff, 0, 0);
    send_item(OP_STATE, 8'hff, 16'd100, 16'd60, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 16'hffff);
    send_item(OP_TICK, 0, 0, 0, 0, 16'h0000);
    send_item(OP_TICK, 0, 0, 0, 0, 16'h8000);
    send_item(OP_JOIN, 8'hff, 0, 0, 24'h00ff00, 0);
    send_item(OP_LEAVE, 8'h00, 0, 0, 0, 0);
    send_item(OP_LEAVE, 8'h00, 0, 0, 0, 0);
    send_item(OP_STATE, 8'h33, 16'hfff0, 16'd3, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 16'h1234);
  endtask

  task automatic test_full_table();
    write_shade(24'hffffff);
    for (int k = 0; k < NumEntries + 2; k++)
      send_item(k[0] ? OP_JOIN : OP_STATE, 8'(8'h80 + k), 16'(k * 7), 16'(-k * 5),
                24'($urandom), 0);
    send_item(OP_JOIN, 8'hfe, 0, 0, 24'h123456, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 16'hffff);
  endtask

  task automatic test_stalled_output();
    // Hold the receiver off for a long stretch while ticks queue up behind it.
    long_hold = 1'b1;
    for (int k = 0; k < 6; k++)
      send_item(OP_TICK, 0, 0, 0, 0, 16'($urandom));
  endtask

  task automatic test_random_traffic(int count);
    op_t op;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    op = OP_LEAVE;
        2, 3:    op = OP_JOIN;
        4, 5, 6: op = OP_STATE;
        default: op = OP_TICK;
      endcase
      send_item(op, pick_key(), pick_pos(), pick_pos(), 24'($urandom),
                $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) * 16'hffff)
                                          : 16'($urandom));
    end
  endtask

  // Receiver: random stall pattern, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 65) || ($urandom_range(0, 7) == 0);
    end
  end

  initial begin
    wait (long_hold);
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_ch.data);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_ch.data);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    shade_colour = '0;
    roster_len = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_full_table();
    test_stalled_output();
    write_shade(24'h000000);
    test_random_traffic(120);
    write_shade(24'h5a3c96);
    test_random_traffic(120);
    write_shade(24'ha5c369);
    test_random_traffic(100);
    drain_block();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
